// File: rtl/sliding_window_maximum_defines.svh
// ----------------------------------------------------------------------------
// Sliding window maximum: assertion macros
// Concurrent checks on i_clk, switched off when SYNTH is defined.
// ----------------------------------------------------------------------------
`ifndef SLIDING_WINDOW_MAXIMUM_DEFINES_SVH
`define SLIDING_WINDOW_MAXIMUM_DEFINES_SVH
`ifndef SYNTH
// property that must hold at every edge out of reset
`define SWM_ASSERT(lbl, expr) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (expr)) \
        else $error("swm check failed");
// implication within the same cycle
`define SWM_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("swm check failed");
// implication into the next cycle
`define SWM_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("swm check failed");
`else
`define SWM_ASSERT(lbl, expr)
`define SWM_ASSERT_NOW(lbl, ante, cons)
`define SWM_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

// File: rtl/swm_pkg.sv
// ----------------------------------------------------------------------------
// Sliding window maximum: package
// Field widths, the ordered entry type and the chain command.
// ----------------------------------------------------------------------------
`default_nettype none

package swm_pkg;

    localparam int unsigned SAMPLE_W       = 32;
    localparam int unsigned IDX_W          = 32;
    localparam int unsigned WIN_W          = 11;
    localparam int unsigned HEAP_DEPTH_DEF = 1024;

    // one queued sample with its running index
    typedef struct packed {
        logic signed [SAMPLE_W-1:0] value;
        logic        [IDX_W-1:0]    index;
    } t_entry;

    // broadcast from the controller to every cell
    typedef struct packed {
        logic   load;   // insert entry at its sorted place
        logic   shift;  // drop the head, everything moves one place up
        t_entry entry;
    } t_chain_cmd;

    // a ranks above b: by signed value, then by index
    function automatic logic entry_above(t_entry a, t_entry b);
        return (a.value > b.value) || ((a.value == b.value) && (a.index > b.index));
    endfunction

endpackage

`default_nettype wire

// File: rtl/swm_if.sv
// ----------------------------------------------------------------------------
// Sliding window maximum: channel interfaces
// Sample input, result output and window size write channel.
// ----------------------------------------------------------------------------
`default_nettype none

interface swm_in_if;
    logic                                 valid;
    logic                                 ready;
    logic signed [swm_pkg::SAMPLE_W-1:0]  sample;
    logic                                 start_req;

    modport source (output valid, output sample, output start_req, input ready);
    modport sink   (input valid, input sample, input start_req, output ready);
endinterface

interface swm_out_if;
    logic                                 valid;
    logic                                 ready;
    logic signed [swm_pkg::SAMPLE_W-1:0]  window_max;
    logic                                 overflow;

    modport source (output valid, output window_max, output overflow, input ready);
    modport sink   (input valid, input window_max, input overflow, output ready);
endinterface

interface swm_cfg_if;
    logic                                 valid;
    logic                                 ready;
    logic        [swm_pkg::WIN_W-1:0]     window_size;

    modport source (output valid, output window_size, input ready);
    modport sink   (input valid, input window_size, output ready);
endinterface

`default_nettype wire

// File: rtl/sliding_window_maximum.sv
// ----------------------------------------------------------------------------
// Sliding window maximum
// Maximum of the last window_size samples, kept in a sorted chain of cells
// with lazy removal of entries that have left the window.
// ----------------------------------------------------------------------------
//  channel  dir  payload                      meaning
//  i_in     in   sample[31:0], start_req      one sample request
//  o_out    out  window_max[31:0], overflow   one result per full window
//  i_cfg    in   window_size[10:0]            window length register
//
//  A sample is accepted in idle; the evict state then drops the k stale
//  head entries, one per cycle by the chain shift (k averages at most one),
//  then checks. Reset is synchronous: clears fill level, counters, state and
//  flags, window to one; no clearing pass. A stalled result holds the final
//  check until the output register frees; the config port is always ready.
// ----------------------------------------------------------------------------
`default_nettype none

module sliding_window_maximum #(
    parameter int unsigned HEAP_DEPTH = swm_pkg::HEAP_DEPTH_DEF
) (
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    swm_in_if.sink      i_in,
    swm_out_if.source   o_out,
    swm_cfg_if.sink     i_cfg
);
    import swm_pkg::*;

    localparam int unsigned CNT_W = $clog2(HEAP_DEPTH + 1);

    t_chain_cmd       w_cmd;
    logic [CNT_W-1:0] w_count;
    t_entry           w_top;

    swm_ctrl #(
        .HEAP_DEPTH (HEAP_DEPTH),
        .CNT_W      (CNT_W)
    ) u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .in_ch   (i_in),
        .out_ch  (o_out),
        .cfg_ch  (i_cfg),
        .i_top   (w_top),
        .o_cmd   (w_cmd),
        .o_count (w_count)
    );

    swm_chain #(
        .HEAP_DEPTH (HEAP_DEPTH),
        .CNT_W      (CNT_W)
    ) u_chain (
        .i_clk   (i_clk),
        .i_cmd   (w_cmd),
        .i_count (w_count),
        .o_top   (w_top)
    );

endmodule

`default_nettype wire

// File: rtl/swm_cell.sv
// ----------------------------------------------------------------------------
// Sliding window maximum: queue cell
// One slot of the sorted chain; takes the new entry, its upper neighbour's
// entry or its lower neighbour's entry.
// ----------------------------------------------------------------------------
`default_nettype none

module swm_cell #(
    parameter int unsigned POS   = 0,
    parameter int unsigned CNT_W = 11
) (
    input  wire logic                  i_clk,
    input  wire swm_pkg::t_chain_cmd   i_cmd,
    input  wire logic [CNT_W-1:0]      i_count,
    input  wire swm_pkg::t_entry       i_prev,
    input  wire logic                  i_prev_gt,
    input  wire swm_pkg::t_entry       i_next,
    output swm_pkg::t_entry            o_entry,
    output logic                       o_gt
);
    import swm_pkg::*;

    t_entry r_entry;
    t_entry n_entry;
    logic   w_empty;

    // slot beyond the fill level, or new entry outranks this one
    assign w_empty = (CNT_W'(POS) >= i_count);
    assign o_gt    = w_empty || entry_above(i_cmd.entry, r_entry);
    assign o_entry = r_entry;

    // next slot contents
    always_comb begin
        n_entry = r_entry;
        if (i_cmd.shift) begin
            n_entry = i_next;
        end else if (i_cmd.load && o_gt) begin
            n_entry = i_prev_gt ? i_prev : i_cmd.entry;
        end
    end

    always_ff @(posedge i_clk) begin
        r_entry <= n_entry;
    end

endmodule

`default_nettype wire

// File: rtl/swm_chain.sv
// ----------------------------------------------------------------------------
// Sliding window maximum: cell chain
// Row of cells kept in descending order; the head is the queue maximum.
// ----------------------------------------------------------------------------
`default_nettype none

module swm_chain #(
    parameter int unsigned HEAP_DEPTH = swm_pkg::HEAP_DEPTH_DEF,
    parameter int unsigned CNT_W      = 11
) (
    input  wire logic                  i_clk,
    input  wire swm_pkg::t_chain_cmd   i_cmd,
    input  wire logic [CNT_W-1:0]      i_count,
    output swm_pkg::t_entry            o_top
);
    import swm_pkg::*;

    t_entry w_entry [HEAP_DEPTH];
    logic   w_gt    [HEAP_DEPTH];

    assign o_top = w_entry[0];

    for (genvar g = 0; g < HEAP_DEPTH; g++) begin : g_cell
        t_entry w_prev;
        t_entry w_next;
        logic   w_prev_gt;

        // head has nobody above it
        if (g == 0) begin : g_head
            assign w_prev    = w_entry[g];
            assign w_prev_gt = 1'b0;
        end else begin : g_body
            assign w_prev    = w_entry[g-1];
            assign w_prev_gt = w_gt[g-1];
        end

        // tail refills from itself; its contents fall past the fill level
        if (g == HEAP_DEPTH - 1) begin : g_tail
            assign w_next = w_entry[g];
        end else begin : g_inner
            assign w_next = w_entry[g+1];
        end

        swm_cell #(
            .POS   (g),
            .CNT_W (CNT_W)
        ) u_cell (
            .i_clk     (i_clk),
            .i_cmd     (i_cmd),
            .i_count   (i_count),
            .i_prev    (w_prev),
            .i_prev_gt (w_prev_gt),
            .i_next    (w_next),
            .o_entry   (w_entry[g]),
            .o_gt      (w_gt[g])
        );
    end

endmodule

`default_nettype wire

// File: rtl/swm_ctrl.sv
// ----------------------------------------------------------------------------
// Sliding window maximum: controller
// Sample index, fill level, eviction of stale heads and the result register.
// ----------------------------------------------------------------------------
`default_nettype none

`include "sliding_window_maximum_defines.svh"

module swm_ctrl #(
    parameter int unsigned HEAP_DEPTH = swm_pkg::HEAP_DEPTH_DEF,
    parameter int unsigned CNT_W      = 11
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    swm_in_if.sink                     in_ch,
    swm_out_if.source                  out_ch,
    swm_cfg_if.sink                    cfg_ch,
    input  wire swm_pkg::t_entry       i_top,
    output swm_pkg::t_chain_cmd        o_cmd,
    output logic [CNT_W-1:0]           o_count
);
    import swm_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE  = 2'b01,
        S_EVICT = 2'b10
    } t_state;

    t_state                     r_state,      n_state;
    logic [CNT_W-1:0]           r_count,      n_count;
    logic [IDX_W-1:0]           r_sample_cnt, n_sample_cnt;
    logic [IDX_W-1:0]           r_cur_idx,    n_cur_idx;
    logic                       r_overflow,   n_overflow;
    logic [WIN_W-1:0]           r_window;
    logic                       r_out_valid,  n_out_valid;
    logic signed [SAMPLE_W-1:0] r_out_max,    n_out_max;
    logic                       r_out_ovf,    n_out_ovf;

    logic             w_in_acc;
    logic             w_start;
    logic [CNT_W-1:0] w_eff_count;
    logic             w_full;
    logic [IDX_W-1:0] w_idx;
    logic [IDX_W-1:0] w_win;
    logic             w_stale;
    logic             w_emit;
    logic             w_out_free;

    // handshakes
    assign in_ch.ready  = (r_state == S_IDLE);
    assign cfg_ch.ready = 1'b1;
    assign w_in_acc     = in_ch.valid && in_ch.ready;
    assign w_start      = w_in_acc && in_ch.start_req;

    // fill level and index as seen by this request
    assign w_eff_count = w_start ? '0 : r_count;
    assign w_full      = (w_eff_count == CNT_W'(HEAP_DEPTH));
    assign w_idx       = w_start ? '0 : r_sample_cnt;

    // zero window counts as one
    assign w_win   = (r_window == '0) ? IDX_W'(1) : IDX_W'(r_window);
    assign w_stale = (r_count != '0) && ((r_cur_idx - i_top.index) >= w_win);
    assign w_emit  = (r_sample_cnt >= w_win);

    assign w_out_free = !r_out_valid || out_ch.ready;

    // chain command
    assign o_cmd.load        = w_in_acc && !w_full;
    assign o_cmd.shift       = (r_state == S_EVICT) && w_stale;
    assign o_cmd.entry.value = in_ch.sample;
    assign o_cmd.entry.index = w_idx;
    assign o_count           = w_eff_count;

    // result channel
    assign out_ch.valid      = r_out_valid;
    assign out_ch.window_max = r_out_max;
    assign out_ch.overflow   = r_out_ovf;

    // sequencer: insert, then drop stale heads one per cycle
    always_comb begin
        n_state      = r_state;
        n_count      = r_count;
        n_sample_cnt = r_sample_cnt;
        n_cur_idx    = r_cur_idx;
        n_overflow   = r_overflow;
        n_out_valid  = r_out_valid;
        n_out_max    = r_out_max;
        n_out_ovf    = r_out_ovf;

        if (r_out_valid && out_ch.ready) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            S_IDLE: begin
                if (w_in_acc) begin
                    n_cur_idx    = w_idx;
                    n_sample_cnt = w_idx + IDX_W'(1);
                    n_overflow   = (w_start ? 1'b0 : r_overflow) | w_full;
                    n_count      = w_full ? w_eff_count : w_eff_count + CNT_W'(1);
                    n_state      = S_EVICT;
                end
            end
            S_EVICT: begin
                if (w_stale) begin
                    n_count = r_count - CNT_W'(1);
                end else if (!w_emit) begin
                    n_state = S_IDLE;
                end else if (w_out_free) begin
                    n_out_valid = 1'b1;
                    n_out_max   = (r_count == '0) ? '0 : i_top.value;
                    n_out_ovf   = r_overflow;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_count      <= '0;
            r_sample_cnt <= '0;
            r_overflow   <= 1'b0;
            r_window     <= WIN_W'(1);
            r_out_valid  <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_count      <= n_count;
            r_sample_cnt <= n_sample_cnt;
            r_overflow   <= n_overflow;
            r_out_valid  <= n_out_valid;
            if (cfg_ch.valid && cfg_ch.ready) begin
                r_window <= cfg_ch.window_size;
            end
        end
    end

    // payload, no reset
    always_ff @(posedge i_clk) begin
        r_cur_idx <= n_cur_idx;
        r_out_max <= n_out_max;
        r_out_ovf <= n_out_ovf;
    end

    // checks
    `SWM_ASSERT(a_count_bound, r_count <= CNT_W'(HEAP_DEPTH))
    `SWM_ASSERT_NEXT(a_evict_dec, o_cmd.shift, r_count == $past(r_count) - CNT_W'(1))
    `SWM_ASSERT_NEXT(a_insert_inc, o_cmd.load && !w_start, r_count == $past(r_count) + CNT_W'(1))
    `SWM_ASSERT_NOW(a_load_from_evict, $rose(r_out_valid), $past(r_state) == S_EVICT)
    `SWM_ASSERT_NOW(a_no_shift_empty, o_cmd.shift, r_count != '0)

endmodule

`default_nettype wire

// File: dv/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Sliding window maximum: testbench
// Streams signed samples into the block and checks every window result, value
// and sticky overflow, against a sorted-list predictor with lazy removal of
// entries that have aged out. Covers sample extremes, zero and widest window,
// warm-up, ties, full heap with empty-after-eviction, back-pressure and
// random phases with random idling on both sides.
// ----------------------------------------------------------------------------

module tb_top;

    localparam int unsigned SAMPLE_W      = swm_pkg::SAMPLE_W;
    localparam int unsigned IDX_W         = swm_pkg::IDX_W;
    localparam int unsigned WIN_W         = swm_pkg::WIN_W;
    localparam int unsigned HEAP_DEPTH    = swm_pkg::HEAP_DEPTH_DEF;
    localparam int unsigned IDLE_PCT      = 21;
    localparam int unsigned SETTLE_CYCLES = 40;
    localparam int unsigned REPORT_LIMIT  = 10;
    localparam int unsigned STALL_CYCLES  = 300;
    localparam int unsigned RANDOM_ITEMS  = 150;

    // content shapes for the random phases
    typedef enum int unsigned {
        PAT_ANY,
        PAT_NARROW,
        PAT_RISING,
        PAT_FALLING,
        PAT_EDGES
    } t_pattern;

    // one sample held by the predictor
    typedef struct packed {
        logic signed [SAMPLE_W-1:0] value;
        logic        [IDX_W-1:0]    index;
    } t_kept_sample;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] window_max;
        logic                       overflow;
    } t_window_result;

    logic i_clk = 1'b0;
    logic i_rst_n;

    swm_in_if  in_ch ();
    swm_out_if out_ch ();
    swm_cfg_if cfg_ch ();

    sliding_window_maximum #(
        .HEAP_DEPTH (HEAP_DEPTH)
    ) dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch),
        .i_cfg   (cfg_ch)
    );

    // predictor state
    t_kept_sample         kept_q[$];
    logic [IDX_W-1:0]     model_count;
    logic                 model_overflow;
    logic [WIN_W-1:0]     model_window;
    t_window_result       pending_results[$];

    // run bookkeeping
    int unsigned          error_count;
    int unsigned          results_checked;
    int unsigned          overflow_results;
    int unsigned          samples_sent;
    int unsigned          windows_written;
    bit                   steady;
    int unsigned          rx_hold_request;
    logic signed [SAMPLE_W-1:0] walk;

    // clock
    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // run limit
    initial begin
        #5_000_000;
        $display("DONE: errors detected");
        $finish;
    end

    task automatic log_failure(input string msg);
        error_count++;
        if (error_count <= REPORT_LIMIT)
            $display("%0t ERROR %s", $realtime, msg);
    endtask

    // a ranks above b: signed value first, then later index
    function automatic logic ranks_above(t_kept_sample a, t_kept_sample b);
        return ($signed(a.value) > $signed(b.value)) ||
               (($signed(a.value) == $signed(b.value)) && (a.index > b.index));
    endfunction

    // advance the predictor by one accepted sample request
    task automatic predict_window(input logic signed [SAMPLE_W-1:0] s, input logic st);
        t_kept_sample      fresh;
        t_window_result    res;
        logic [IDX_W-1:0]  idx;
        logic [IDX_W-1:0]  span;
        int                pos;
        span = (model_window == '0) ? 1 : IDX_W'(model_window);
        if (st) begin
            kept_q.delete();
            model_count    = '0;
            model_overflow = 1'b0;
        end
        idx         = model_count;
        model_count = model_count + 1'b1;
        // keep the list sorted, highest rank first; drop when full
        if (kept_q.size() < HEAP_DEPTH) begin
            fresh.value = s;
            fresh.index = idx;
            pos = 0;
            while (pos < kept_q.size() && !ranks_above(fresh, kept_q[pos]))
                pos++;
            kept_q.insert(pos, fresh);
        end else begin
            model_overflow = 1'b1;
        end
        // lazy removal: only the head is checked for age
        while (kept_q.size() > 0 && (idx - kept_q[0].index) >= span)
            void'(kept_q.pop_front());
        if (model_count >= span) begin
            res.window_max = (kept_q.size() > 0) ? kept_q[0].value : '0;
            res.overflow   = model_overflow;
            pending_results.push_back(res);
        end
    endtask

    // offer one sample request, with random idle cycles ahead of it
    task automatic send_sample(input logic signed [SAMPLE_W-1:0] s, input logic st);
        while (!steady && $urandom_range(99) < IDLE_PCT) begin
            in_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        in_ch.valid     <= 1'b1;
        in_ch.sample    <= s;
        in_ch.start_req <= st;
        @(posedge i_clk);
        while (!in_ch.ready)
            @(posedge i_clk);
        predict_window(s, st);
        samples_sent++;
    endtask

    // drain, let the block settle, then write the window register
    task automatic set_window(input logic [WIN_W-1:0] w);
        in_ch.valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        cfg_ch.valid       <= 1'b1;
        cfg_ch.window_size <= w;
        @(posedge i_clk);
        while (!cfg_ch.ready)
            @(posedge i_clk);
        cfg_ch.valid <= 1'b0;
        model_window = w;
        windows_written++;
    endtask

    function automatic logic signed [SAMPLE_W-1:0] pattern_sample(input t_pattern p);
        logic signed [SAMPLE_W-1:0] v;
        case (p)
            PAT_NARROW:  v = $signed(SAMPLE_W'($urandom_range(0, 6))) - 3;
            PAT_RISING: begin
                walk = walk + $signed(SAMPLE_W'($urandom_range(0, 1000)));
                v = walk;
            end
            PAT_FALLING: begin
                walk = walk - $signed(SAMPLE_W'($urandom_range(0, 1000)));
                v = walk;
            end
            PAT_EDGES: begin
                case ($urandom_range(3))
                    0:       v = {1'b1, {(SAMPLE_W-1){1'b0}}};
                    1:       v = {1'b0, {(SAMPLE_W-1){1'b1}}};
                    2:       v = '0;
                    default: v = '1;
                endcase
            end
            default:     v = $urandom;
        endcase
        return v;
    endfunction

    // result receiver: random stalls, steady stretches, long hold on request
    initial begin : result_ready
        int unsigned hold_left;
        hold_left = 0;
        out_ch.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (rx_hold_request > 0) begin
                hold_left       = rx_hold_request;
                rx_hold_request = 0;
            end
            if (hold_left > 0) begin
                out_ch.ready <= 1'b0;
                hold_left--;
            end else if (steady) begin
                out_ch.ready <= 1'b1;
            end else begin
                out_ch.ready <= ($urandom_range(99) >= IDLE_PCT);
            end
        end
    end

    // compare each accepted result with the oldest prediction
    always @(posedge i_clk) begin : result_check
        t_window_result want;
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            if (pending_results.size() == 0) begin
                log_failure($sformatf("result with none expected: max %0d ovf %0b",
                                      out_ch.window_max, out_ch.overflow));
            end else begin
                want = pending_results.pop_front();
                results_checked++;
                if (want.overflow)
                    overflow_results++;
                if (out_ch.window_max !== want.window_max)
                    log_failure($sformatf("window_max exp %0d got %0d",
                                          want.window_max, out_ch.window_max));
                if (out_ch.overflow !== want.overflow)
                    log_failure($sformatf("overflow exp %0b got %0b",
                                          want.overflow, out_ch.overflow));
            end
        end
    end

    // ---------------------------------------------------------------- tests

    // sample field extremes at window 1
    task automatic test_sample_extremes();
        set_window(1);
        send_sample({1'b1, {(SAMPLE_W-1){1'b0}}}, 1'b1);
        send_sample({1'b0, {(SAMPLE_W-1){1'b1}}}, 1'b0);
        send_sample('0, 1'b0);
        send_sample('1, 1'b0);
        send_sample(1, 1'b0);
        send_sample(32'h5555_5555, 1'b0);
        send_sample(32'hAAAA_AAAA, 1'b0);
    endtask

    // a zero window acts as a window of one
    task automatic test_zero_window();
        set_window(0);
        send_sample(10, 1'b1);
        send_sample(-3, 1'b0);
        send_sample(-3, 1'b0);
    endtask

    // warm-up, equal values, ageing out, restart mid-stream
    task automatic test_warm_up_and_ties();
        set_window(3);
        send_sample(5, 1'b1);
        send_sample(5, 1'b0);
        send_sample(5, 1'b0);
        send_sample(9, 1'b0);
        send_sample(2, 1'b0);
        send_sample(2, 1'b0);
        send_sample(2, 1'b0);
        send_sample(2, 1'b0);
        send_sample(7, 1'b1);
        send_sample(-1, 1'b0);
        send_sample(4, 1'b0);
        send_sample(4, 1'b0);
    endtask

    // rising run fills the heap at window 1024, then window 1 empties it
    task automatic test_full_heap();
        set_window(1024);
        walk = {1'b1, {(SAMPLE_W-1){1'b0}}} + $signed(SAMPLE_W'($urandom_range(0, 999)));
        for (int i = 0; i < HEAP_DEPTH + 6; i++) begin
            send_sample(walk, i == 0);
            walk = walk + $signed(SAMPLE_W'($urandom_range(0, 1 << 21)));
        end
        // heap still full: sample dropped, every entry aged out, empty result
        set_window(1);
        send_sample($urandom, 1'b0);
        send_sample($urandom, 1'b0);
        send_sample($urandom, 1'b0);
    endtask

    // widest window: warm-up only
    task automatic test_long_window();
        set_window({WIN_W{1'b1}});
        for (int i = 0; i < 40; i++)
            send_sample($urandom, i == 0);
    endtask

    // receiver holds off while requests keep coming
    task automatic test_receiver_stall();
        set_window(WIN_W'($urandom_range(1, 6)));
        rx_hold_request = STALL_CYCLES;
        for (int i = 0; i < 150; i++)
            send_sample($urandom, i == 0);
    endtask

    // no idling on either side
    task automatic test_steady_stream();
        set_window(4);
        steady = 1'b1;
        for (int i = 0; i < 200; i++)
            send_sample(pattern_sample(t_pattern'($urandom_range(0, 4))), i == 0);
        steady = 1'b0;
    endtask

    // sender pauses until every pending result is in, then carries on
    task automatic test_sender_pause();
        set_window(5);
        for (int i = 0; i < 30; i++)
            send_sample($urandom, i == 0);
        in_ch.valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge i_clk);
        for (int i = 0; i < 30; i++)
            send_sample(pattern_sample(PAT_NARROW), 1'b0);
    endtask

    // random windows and content, with restarts now and then
    task automatic test_random_phases();
        int unsigned sent;
        int unsigned len;
        t_pattern    pat;
        logic        first_start;
        logic [WIN_W-1:0] w;
        sent = 0;
        while (sent < RANDOM_ITEMS) begin
            case ($urandom_range(9))
                0:       w = 0;
                1, 2:    w = WIN_W'($urandom_range(9, 40));
                default: w = WIN_W'($urandom_range(1, 8));
            endcase
            set_window(w);
            pat         = t_pattern'($urandom_range(0, 4));
            len         = $urandom_range(20, 70);
            first_start = ($urandom_range(3) != 0);
            walk        = $urandom;
            for (int i = 0; i < len; i++)
                send_sample(pattern_sample(pat),
                            (i == 0) ? first_start : ($urandom_range(39) == 0));
            sent += len;
        end
    endtask

    // ---------------------------------------------------------------- main
    initial begin
        error_count      = 0;
        results_checked  = 0;
        overflow_results = 0;
        samples_sent     = 0;
        windows_written  = 0;
        steady           = 1'b0;
        rx_hold_request  = 0;
        walk             = '0;
        model_count      = '0;
        model_overflow   = 1'b0;
        model_window     = 1;

        i_rst_n            <= 1'b0;
        in_ch.valid        <= 1'b0;
        in_ch.sample       <= '0;
        in_ch.start_req    <= 1'b0;
        cfg_ch.valid       <= 1'b0;
        cfg_ch.window_size <= '0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_sample_extremes();
        test_zero_window();
        test_warm_up_and_ties();
        test_full_heap();
        test_long_window();
        test_receiver_stall();
        test_steady_stream();
        test_sender_pause();
        test_random_phases();

        // drain and let the block go quiet
        in_ch.valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);

        $display("Sent %0d samples over %0d window settings; checked %0d results",
                 samples_sent, windows_written, results_checked);
        $display("%0d results carried overflow; %0d failures counted",
                 overflow_results, error_count);
        if (error_count == 0 && pending_results.size() == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
